// File: sv/htc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_pkg
// Shared widths, constants and register indexes for the two-point
// humidity / temperature calibration pipeline.
// ----------------------------------------------------------------------------
package htc_pkg;

    // Raw sample and calibration point widths
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned POINT_W   = 7;              // whole percent / whole degree
    localparam int unsigned DIFF_W    = SAMPLE_W + 1;   // s - r0, r1 - r0
    localparam int unsigned SCALE_W   = 12;             // (p1 - p0) * 10, signed
    localparam int unsigned BASE_W    = 11;             // p0 * 10, unsigned, <= 1270
    localparam int unsigned PROD_W    = DIFF_W + SCALE_W;
    localparam int unsigned MAG_W     = 27;             // |product| < 2^27
    localparam int unsigned DEN_W     = SAMPLE_W;       // |span| <= 65535
    localparam int unsigned RES_W     = 32;

    // Pipeline depth: input diff, multiply, magnitude, one stage per quotient bit
    localparam int unsigned DIV_STAGES  = MAG_W;
    localparam int unsigned CORE_STAGES = 3 + DIV_STAGES;
    localparam int unsigned TOTAL_STAGES = CORE_STAGES + 1;

    // Scaling and clamp
    localparam int          TENTHS    = 10;
    localparam int          HUM_CLAMP = 1000;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_HUM_P0_HALF   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_P1_HALF   = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_P0_RAW    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_P1_RAW    = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_P0_EIGHT = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_P1_EIGHT = CFG_ADDR_W'(5);
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_P0_RAW   = CFG_ADDR_W'(6);
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_P1_RAW   = CFG_ADDR_W'(7);

endpackage

// File: sv/htc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_interp
// One channel of two-point linear interpolation:
//   p0*10 + (s - r0) * (p1 - p0) * 10 / (r1 - r0), truncated toward zero.
// Datapath only; stage enables come from the valid/ready control in the top.
// The division is a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module htc_interp (
    input  logic                                aclk,
    input  logic [htc_pkg::CORE_STAGES-1:0]     stage_en,
    input  logic signed [htc_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [htc_pkg::SAMPLE_W-1:0] raw0,
    input  logic signed [htc_pkg::SAMPLE_W-1:0] raw1,
    input  logic [htc_pkg::POINT_W-1:0]         point0,
    input  logic [htc_pkg::POINT_W-1:0]         point1,
    output logic signed [htc_pkg::RES_W-1:0]    result,
    output logic                                fault
);

    localparam int unsigned DIFF_W  = htc_pkg::DIFF_W;
    localparam int unsigned SCALE_W = htc_pkg::SCALE_W;
    localparam int unsigned BASE_W  = htc_pkg::BASE_W;
    localparam int unsigned PROD_W  = htc_pkg::PROD_W;
    localparam int unsigned MAG_W   = htc_pkg::MAG_W;
    localparam int unsigned DEN_W   = htc_pkg::DEN_W;
    localparam int unsigned RES_W   = htc_pkg::RES_W;
    localparam int unsigned NDIV    = htc_pkg::DIV_STAGES;

    // ---- stage 0: offsets, span, point delta --------------------------------
    logic signed [DIFF_W-1:0]  diff_next, diff_reg;
    logic signed [DIFF_W-1:0]  span_next, span0_reg;
    logic signed [SCALE_W-1:0] scale_next, scale_reg;
    logic [BASE_W-1:0]         base_next, base0_reg;
    logic                      fault_next, fault0_reg;
    logic signed [SCALE_W-1:0] pdelta;

    always_comb begin
        diff_next  = {sample[htc_pkg::SAMPLE_W-1], sample} - {raw0[htc_pkg::SAMPLE_W-1], raw0};
        span_next  = {raw1[htc_pkg::SAMPLE_W-1], raw1} - {raw0[htc_pkg::SAMPLE_W-1], raw0};
        pdelta     = SCALE_W'($signed({1'b0, point1})) - SCALE_W'($signed({1'b0, point0}));
        scale_next = SCALE_W'(pdelta * SCALE_W'(htc_pkg::TENTHS));
        base_next  = BASE_W'(BASE_W'(point0) * BASE_W'(htc_pkg::TENTHS));
        fault_next = (raw1 == raw0);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            diff_reg   <= diff_next;
            span0_reg  <= span_next;
            scale_reg  <= scale_next;
            base0_reg  <= base_next;
            fault0_reg <= fault_next;
        end
    end

    // ---- stage 1: signed product --------------------------------------------
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [DIFF_W-1:0] span1_reg;
    logic [BASE_W-1:0]        base1_reg;
    logic                     fault1_reg;

    assign prod_next = PROD_W'(diff_reg) * PROD_W'(scale_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg   <= prod_next;
            span1_reg  <= span0_reg;
            base1_reg  <= base0_reg;
            fault1_reg <= fault0_reg;
        end
    end

    // ---- stage 2 and divider stages -----------------------------------------
    // Entry 0 holds the magnitudes, entry k the state after k quotient bits.
    logic [MAG_W-1:0]  work_reg  [NDIV+1];
    logic [DEN_W-1:0]  rem_reg   [NDIV+1];
    logic [DEN_W-1:0]  den_reg   [NDIV+1];
    logic              neg_reg   [NDIV+1];
    logic [BASE_W-1:0] base_reg  [NDIV+1];
    logic              fault_reg [NDIV+1];

    logic [PROD_W-1:0] prod_abs;
    logic [DIFF_W-1:0] span_abs;

    always_comb begin
        prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        span_abs = span1_reg[DIFF_W-1] ? DIFF_W'(-span1_reg) : DIFF_W'(span1_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            work_reg[0]  <= prod_abs[MAG_W-1:0];
            rem_reg[0]   <= '0;
            den_reg[0]   <= span_abs[DEN_W-1:0];
            neg_reg[0]   <= prod_reg[PROD_W-1] ^ span1_reg[DIFF_W-1];
            base_reg[0]  <= base1_reg;
            fault_reg[0] <= fault1_reg;
        end
    end

    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        logic [DEN_W:0]   trial;
        logic             qbit;
        logic [DEN_W-1:0] rem_next;
        logic [MAG_W-1:0] work_next;

        // shift in next dividend bit, subtract divisor if it fits
        always_comb begin
            trial     = {rem_reg[k-1], work_reg[k-1][MAG_W-1]};
            qbit      = (trial >= {1'b0, den_reg[k-1]});
            rem_next  = qbit ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : trial[DEN_W-1:0];
            work_next = {work_reg[k-1][MAG_W-2:0], qbit};
        end

        always_ff @(posedge aclk) begin
            if (stage_en[2 + k]) begin
                work_reg[k]  <= work_next;
                rem_reg[k]   <= rem_next;
                den_reg[k]   <= den_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                base_reg[k]  <= base_reg[k-1];
                fault_reg[k] <= fault_reg[k-1];
            end
        end
    end

    // ---- sign restore and offset --------------------------------------------
    logic signed [MAG_W:0] quot_signed;

    always_comb begin
        quot_signed = neg_reg[NDIV] ? -$signed({1'b0, work_reg[NDIV]})
                                    :  $signed({1'b0, work_reg[NDIV]});
        if (fault_reg[NDIV]) begin
            result = '0;
        end else begin
            result = RES_W'(quot_signed) + $signed(RES_W'(base_reg[NDIV]));
        end
        fault = fault_reg[NDIV];
    end

endmodule

// File: sv/humidity_temp_calibration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_calibration
// Two-point linear calibration of raw humidity and temperature samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one beat carries both raw samples (signed 16 bit each).
//   m_* : one beat per input beat: humidity in tenths of a percent (clamped
//         above at 1000), temperature in tenths of a degree, and two fault
//         flags in m_tuser that mark a zero calibration span; a faulted
//         field reads 0.
//   cfg_* : eight calibration registers, written while no beat is in flight.
// The pipeline has three setup stages (offset, multiply, magnitude), 27
// restoring-divider stages (one quotient bit each) and the output
// register. Throughput is one beat per cycle while m_tready is high.
// Each stage holds its own valid bit; when m_tready is low, stages fill
// until the pipeline is full and only then does s_tready drop, so bubbles
// are squeezed out and nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets all
// calibration registers to zero.
// ----------------------------------------------------------------------------
module humidity_temp_calibration (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [htc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [htc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // humidity_sample, temperature_sample
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,  // humidity_tenths, temperature_tenths
    output logic [1:0]                        m_tuser   // humidity_fault, temperature_fault
);

    localparam int unsigned SAMPLE_W = htc_pkg::SAMPLE_W;
    localparam int unsigned RES_W    = htc_pkg::RES_W;
    localparam int unsigned NCORE    = htc_pkg::CORE_STAGES;
    localparam int unsigned NTOTAL   = htc_pkg::TOTAL_STAGES;

    // ---- calibration registers ----------------------------------------------
    logic [7:0]          hum_p0_half_reg, hum_p1_half_reg;
    logic [SAMPLE_W-1:0] hum_p0_raw_reg, hum_p1_raw_reg;
    logic [9:0]          temp_p0_eighth_reg, temp_p1_eighth_reg;
    logic [SAMPLE_W-1:0] temp_p0_raw_reg, temp_p1_raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_p0_half_reg    <= '0;
            hum_p1_half_reg    <= '0;
            hum_p0_raw_reg     <= '0;
            hum_p1_raw_reg     <= '0;
            temp_p0_eighth_reg <= '0;
            temp_p1_eighth_reg <= '0;
            temp_p0_raw_reg    <= '0;
            temp_p1_raw_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                htc_pkg::REG_HUM_P0_HALF:   hum_p0_half_reg    <= cfg_wdata[7:0];
                htc_pkg::REG_HUM_P1_HALF:   hum_p1_half_reg    <= cfg_wdata[7:0];
                htc_pkg::REG_HUM_P0_RAW:    hum_p0_raw_reg     <= cfg_wdata;
                htc_pkg::REG_HUM_P1_RAW:    hum_p1_raw_reg     <= cfg_wdata;
                htc_pkg::REG_TEMP_P0_EIGHT: temp_p0_eighth_reg <= cfg_wdata[9:0];
                htc_pkg::REG_TEMP_P1_EIGHT: temp_p1_eighth_reg <= cfg_wdata[9:0];
                htc_pkg::REG_TEMP_P0_RAW:   temp_p0_raw_reg    <= cfg_wdata;
                htc_pkg::REG_TEMP_P1_RAW:   temp_p1_raw_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- per-stage valid and enable -----------------------------------------
    // A stage may load when it or any stage downstream is empty, or the
    // receiver takes the output beat.
    logic [NTOTAL-1:0] valid_reg;
    logic [NTOTAL-1:0] stage_en;

    for (genvar i = 0; i < NTOTAL; i++) begin : g_en
        assign stage_en[i] = m_tready || !(&valid_reg[NTOTAL-1:i]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NTOTAL; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];

    // ---- interpolation channels ---------------------------------------------
    logic signed [RES_W-1:0] hum_res, temp_res;
    logic                    hum_fault, temp_fault;

    htc_interp u_hum (
        .aclk     (aclk),
        .stage_en (stage_en[NCORE-1:0]),
        .sample   ($signed(s_tdata[SAMPLE_W-1:0])),
        .raw0     ($signed(hum_p0_raw_reg)),
        .raw1     ($signed(hum_p1_raw_reg)),
        .point0   (hum_p0_half_reg[7:1]),
        .point1   (hum_p1_half_reg[7:1]),
        .result   (hum_res),
        .fault    (hum_fault)
    );

    htc_interp u_temp (
        .aclk     (aclk),
        .stage_en (stage_en[NCORE-1:0]),
        .sample   ($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .raw0     ($signed(temp_p0_raw_reg)),
        .raw1     ($signed(temp_p1_raw_reg)),
        .point0   (temp_p0_eighth_reg[9:3]),
        .point1   (temp_p1_eighth_reg[9:3]),
        .result   (temp_res),
        .fault    (temp_fault)
    );

    // ---- humidity clamp and output register ---------------------------------
    logic signed [RES_W-1:0] hum_next, hum_out_reg, temp_out_reg;
    logic                    hum_fault_reg, temp_fault_reg;

    always_comb begin
        if (hum_res > $signed(RES_W'(htc_pkg::HUM_CLAMP))) begin
            hum_next = RES_W'(htc_pkg::HUM_CLAMP);
        end else begin
            hum_next = hum_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NTOTAL-1]) begin
            hum_out_reg    <= hum_next;
            temp_out_reg   <= temp_res;
            hum_fault_reg  <= hum_fault;
            temp_fault_reg <= temp_fault;
        end
    end

    assign m_tvalid = valid_reg[NTOTAL-1];
    assign m_tdata  = {temp_out_reg, hum_out_reg};
    assign m_tuser  = {temp_fault_reg, hum_fault_reg};

`ifndef SYNTHESIS
    // input is only refused when every stage holds a beat
    a_full_when_blocked : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &valid_reg)
        else $error("s_tready low with an empty pipeline stage");

    // humidity never exceeds the clamp
    a_hum_clamp : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[31:0]) <= $signed(RES_W'(htc_pkg::HUM_CLAMP)))
        else $error("humidity above clamp");

    // a faulted field reads zero
    a_fault_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |->
            (!m_tuser[0] || m_tdata[31:0] == '0) && (!m_tuser[1] || m_tdata[63:32] == '0))
        else $error("fault flag with nonzero field");

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: test/humidity_temp_calibration_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_calibration_tb
// Self-checking bench for the two-point humidity / temperature calibration
// pipeline. The bench programs a series of calibration settings, including
// zero spans, spans of one, reversed spans and the register extremes. Under
// each setting it streams raw sample pairs: a short directed set first, then
// random beats. A local integer model computes every expected result when
// the input beat is accepted. Each output beat is compared against it field
// by field. Both stream sides idle at random, and one long receiver hold-off
// fills the pipeline until the input side stalls.
// ----------------------------------------------------------------------------
module humidity_temp_calibration_tb;

    localparam int CLK_HALF      = 4;
    localparam int IDLE_PCT      = 11;
    localparam int DRAIN_CYCLES  = 40;      // pipeline is 31 deep
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_PHASES   = 10;
    localparam int RAND_BEATS    = 130;
    localparam int QUIET_PHASE   = 2;
    localparam int HOLD_PHASE    = 5;

    // Calibration register image, kept at register widths
    typedef struct {
        logic [7:0]         hum_p0_half;
        logic [7:0]         hum_p1_half;
        logic signed [15:0] hum_p0_raw;
        logic signed [15:0] hum_p1_raw;
        logic [9:0]         temp_p0_eighth;
        logic [9:0]         temp_p1_eighth;
        logic signed [15:0] temp_p0_raw;
        logic signed [15:0] temp_p1_raw;
    } cal_regs_t;

    typedef struct {
        logic signed [31:0] hum_tenths;
        logic signed [31:0] temp_tenths;
        logic               hum_fault;
        logic               temp_fault;
    } reading_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [htc_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [htc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;   // humidity_sample, temperature_sample
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [63:0]                     m_tdata;          // humidity_tenths, temperature_tenths
    logic [1:0]                      m_tuser;          // humidity_fault, temperature_fault

    cal_regs_t      cal;
    logic [31:0]    sample_queue[$];
    reading_t       reading_queue[$];
    bit             no_idle    = 1'b0;
    logic           hold_req   = 1'b0;
    logic           hold_done  = 1'b0;
    int             hold_left  = 0;
    int             stall_cnt  = 0;
    int             error_cnt  = 0;
    int             beats_checked = 0;
    int             clamp_hits = 0;
    int             fault_hits = 0;
    int             setting_cnt = 0;

    humidity_temp_calibration dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Two-point interpolation, quotient truncated toward zero
    function automatic longint two_point(longint s, longint r0, longint r1,
                                         longint p0, longint p1, output logic fault);
        longint span;
        span = r1 - r0;
        if (span == 0) begin
            fault = 1'b1;
            return 0;
        end
        fault = 1'b0;
        return ((s - r0) * ((p1 - p0) * htc_pkg::TENTHS)) / span + p0 * htc_pkg::TENTHS;
    endfunction

    function automatic reading_t calibrate(logic [31:0] beat);
        reading_t           r;
        longint             hum;
        longint             tmp;
        logic signed [15:0] hs;
        logic signed [15:0] ts;
        hs  = beat[15:0];
        ts  = beat[31:16];
        hum = two_point(hs, cal.hum_p0_raw, cal.hum_p1_raw,
                        longint'(cal.hum_p0_half >> 1), longint'(cal.hum_p1_half >> 1),
                        r.hum_fault);
        if (hum > htc_pkg::HUM_CLAMP)
            hum = htc_pkg::HUM_CLAMP;
        tmp = two_point(ts, cal.temp_p0_raw, cal.temp_p1_raw,
                        longint'(cal.temp_p0_eighth >> 3), longint'(cal.temp_p1_eighth >> 3),
                        r.temp_fault);
        r.hum_tenths  = hum[31:0];
        r.temp_tenths = tmp[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH beat %0d %s: got %0d expected %0d",
                 beats_checked, field, got, want);
        error_cnt++;
    endtask

    // One register write; bits above the register width carry random junk
    task automatic write_reg(logic [htc_pkg::CFG_ADDR_W-1:0] idx,
                             logic [htc_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            htc_pkg::REG_HUM_P0_HALF:   cal.hum_p0_half    = val[7:0];
            htc_pkg::REG_HUM_P1_HALF:   cal.hum_p1_half    = val[7:0];
            htc_pkg::REG_HUM_P0_RAW:    cal.hum_p0_raw     = val;
            htc_pkg::REG_HUM_P1_RAW:    cal.hum_p1_raw     = val;
            htc_pkg::REG_TEMP_P0_EIGHT: cal.temp_p0_eighth = val[9:0];
            htc_pkg::REG_TEMP_P1_EIGHT: cal.temp_p1_eighth = val[9:0];
            htc_pkg::REG_TEMP_P0_RAW:   cal.temp_p0_raw    = val;
            htc_pkg::REG_TEMP_P1_RAW:   cal.temp_p1_raw    = val;
            default: ;
        endcase
    endtask

    task automatic program_cal(cal_regs_t c);
        logic [htc_pkg::CFG_DATA_W-1:0] junk;
        junk = htc_pkg::CFG_DATA_W'($urandom);
        write_reg(htc_pkg::REG_HUM_P0_HALF,   {junk[15:8], c.hum_p0_half});
        junk = htc_pkg::CFG_DATA_W'($urandom);
        write_reg(htc_pkg::REG_HUM_P1_HALF,   {junk[15:8], c.hum_p1_half});
        write_reg(htc_pkg::REG_HUM_P0_RAW,    c.hum_p0_raw);
        write_reg(htc_pkg::REG_HUM_P1_RAW,    c.hum_p1_raw);
        junk = htc_pkg::CFG_DATA_W'($urandom);
        write_reg(htc_pkg::REG_TEMP_P0_EIGHT, {junk[15:10], c.temp_p0_eighth});
        junk = htc_pkg::CFG_DATA_W'($urandom);
        write_reg(htc_pkg::REG_TEMP_P1_EIGHT, {junk[15:10], c.temp_p1_eighth});
        write_reg(htc_pkg::REG_TEMP_P0_RAW,   c.temp_p0_raw);
        write_reg(htc_pkg::REG_TEMP_P1_RAW,   c.temp_p1_raw);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        setting_cnt++;
    endtask

    // Wait until every queued beat is in and every result is out
    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || reading_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic cal_regs_t make_cal(int h0, int h1, int hr0, int hr1,
                                           int t0, int t1, int tr0, int tr1);
        cal_regs_t c;
        c.hum_p0_half    = 8'(h0);
        c.hum_p1_half    = 8'(h1);
        c.hum_p0_raw     = 16'(hr0);
        c.hum_p1_raw     = 16'(hr1);
        c.temp_p0_eighth = 10'(t0);
        c.temp_p1_eighth = 10'(t1);
        c.temp_p0_raw    = 16'(tr0);
        c.temp_p1_raw    = 16'(tr1);
        return c;
    endfunction

    // Random raw point pair: mostly wide, sometimes narrow or zero span
    function automatic void rand_raw_pair(output logic signed [15:0] r0,
                                          output logic signed [15:0] r1);
        int pick;
        pick = $urandom_range(0, 99);
        r0 = 16'($urandom);
        if (pick < 10)
            r1 = r0;
        else if (pick < 30)
            r1 = 16'(r0 + 16'($urandom_range(1, 8)) *
                     (($urandom_range(0, 1) != 0) ? 1 : -1));
        else
            r1 = 16'($urandom);
    endfunction

    function automatic cal_regs_t rand_cal();
        cal_regs_t c;
        c.hum_p0_half    = 8'($urandom);
        c.hum_p1_half    = 8'($urandom);
        c.temp_p0_eighth = 10'($urandom);
        c.temp_p1_eighth = 10'($urandom);
        rand_raw_pair(c.hum_p0_raw, c.hum_p1_raw);
        rand_raw_pair(c.temp_p0_raw, c.temp_p1_raw);
        return c;
    endfunction

    // Raw sample: full range most of the time, else near a calibration point
    function automatic logic [15:0] rand_sample(logic signed [15:0] r0,
                                                logic signed [15:0] r1);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 16'($urandom);
        else if (pick < 85)
            return r0 + 16'($urandom_range(0, 20)) - 16'd10;
        else
            return r1 + 16'($urandom_range(0, 20)) - 16'd10;
    endfunction

    task automatic queue_beat(logic [15:0] hum, logic [15:0] tmp);
        sample_queue.push_back({tmp, hum});
    endtask

    // Input driver: predicts on acceptance, then offers the next beat
    always @(posedge aclk) begin : drive_samples
        logic        nxt_valid;
        logic [31:0] nxt_data;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                reading_queue.push_back(calibrate(s_tdata));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && sample_queue.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt_data  = sample_queue.pop_front();
                nxt_valid = 1'b1;
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor and ready generation
    always @(posedge aclk) begin : check_readings
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reading_queue.size() == 0) begin
                    report_mismatch("output beat with no pending result", 1, 0);
                end else begin
                    want = reading_queue.pop_front();
                    if (m_tdata[31:0] !== want.hum_tenths)
                        report_mismatch("humidity_tenths", $signed(m_tdata[31:0]),
                                        want.hum_tenths);
                    if (m_tdata[63:32] !== want.temp_tenths)
                        report_mismatch("temperature_tenths", $signed(m_tdata[63:32]),
                                        want.temp_tenths);
                    if (m_tuser[0] !== want.hum_fault)
                        report_mismatch("humidity_fault", m_tuser[0], want.hum_fault);
                    if (m_tuser[1] !== want.temp_fault)
                        report_mismatch("temperature_fault", m_tuser[1], want.temp_fault);
                    if (!want.hum_fault && want.hum_tenths == htc_pkg::HUM_CLAMP)
                        clamp_hits++;
                    if (want.hum_fault || want.temp_fault)
                        fault_hits++;
                end
                beats_checked++;
            end
            m_tready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("humidity_temp_calibration verification failed");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin : run_phases
        cal_regs_t c;
        cal = make_cal(0, 0, 0, 0, 0, 0, 0, 0);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: both spans zero
        @(negedge aclk);
        queue_beat(16'h0000, 16'h0000);
        queue_beat(16'h7FFF, 16'h8000);
        queue_beat(16'h8000, 16'h7FFF);
        wait_drained();

        // Typical setting, samples on and beyond the points
        program_cal(make_cal(40, 160, -10000, 12000, 80, 480, -20000, 20000));
        @(negedge aclk);
        queue_beat(-16'sd10000, -16'sd20000);
        queue_beat(16'sd12000, 16'sd20000);
        queue_beat(16'h8000, 16'h8000);
        queue_beat(16'h7FFF, 16'h7FFF);
        queue_beat(16'h0000, 16'h0000);
        queue_beat(16'hFFFF, 16'hFFFF);
        queue_beat(16'h5555, 16'hAAAA);
        queue_beat(16'hAAAA, 16'h5555);
        wait_drained();

        // Register extremes, widest spans, reversed temperature span
        program_cal(make_cal(0, 255, -32768, 32767, 1023, 0, 32767, -32768));
        @(negedge aclk);
        queue_beat(16'h8000, 16'h7FFF);
        queue_beat(16'h7FFF, 16'h8000);
        queue_beat(16'h0000, 16'h0000);
        queue_beat(16'hFFFF, 16'h0001);
        queue_beat(16'h4000, 16'hC000);
        queue_beat(16'h7FFF, 16'h7FFF);
        wait_drained();

        // Span of one: far beyond the clamp and deeply negative
        program_cal(make_cal(255, 0, 100, 101, 1023, 7, -5, -6));
        @(negedge aclk);
        queue_beat(16'h7FFF, 16'h7FFF);
        queue_beat(16'h8000, 16'h8000);
        queue_beat(16'd100, -16'sd5);
        queue_beat(16'd102, -16'sd7);
        wait_drained();

        // Humidity span zero only
        program_cal(make_cal(10, 200, 1234, 1234, 16, 800, -3000, 3000));
        @(negedge aclk);
        queue_beat(16'd1234, 16'd0);
        queue_beat(16'h8000, 16'h7FFF);
        wait_drained();

        // Temperature span zero only
        program_cal(make_cal(10, 200, -3000, 3000, 16, 800, 777, 777));
        @(negedge aclk);
        queue_beat(16'd0, 16'd777);
        queue_beat(16'h7FFF, 16'h8000);
        wait_drained();

        // Random settings, each with a batch of random samples
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            c = rand_cal();
            program_cal(c);
            @(negedge aclk);
            no_idle = (ph == QUIET_PHASE);
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;
            for (int i = 0; i < RAND_BEATS; i++)
                queue_beat(rand_sample(c.hum_p0_raw, c.hum_p1_raw),
                           rand_sample(c.temp_p0_raw, c.temp_p1_raw));
            wait_drained();
            no_idle = 1'b0;
        end

        $display("ran %0d calibration settings, %0d result beats checked",
                 setting_cnt + 1, beats_checked);
        $display("results at the humidity clamp: %0d, with a span fault: %0d",
                 clamp_hits, fault_hits);
        if (error_cnt == 0) begin
            $display("humidity_temp_calibration verification clean");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("humidity_temp_calibration verification failed");
        end
        $finish;
    end

endmodule
